>>> hw/rtl/mrrt_pkg.sv
// Shared types and constants for the masked radar rain total block.
// Used by every module under hw/rtl; depends on nothing else.
package mrrt_pkg;

   // Largest image dimension; coordinates at or beyond it are never counted
   localparam int MAX_DIM = 1024;

   localparam int COORD_W = 10;
   localparam int WIN_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 28;
   localparam int CSR_IDX_W = 3;

   localparam logic [WIN_W-1:0]   WIN_END_RESET = WIN_W'(MAX_DIM);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAY_MODE      = 3'd0,
      CSR_WINDOW_X_FIRST = 3'd1,
      CSR_WINDOW_X_END   = 3'd2,
      CSR_WINDOW_Y_FIRST = 3'd3,
      CSR_WINDOW_Y_END   = 3'd4
   } csr_index_type;

   // Palette reference values
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [BYTE_W-1:0] RED_L1       = 8'd0;
   localparam logic [BYTE_W-1:0] RED_L3       = 8'd50;
   localparam logic [BYTE_W-1:0] RED_L6       = 8'd127;
   localparam logic [BYTE_W-1:0] RED_L192     = 8'd229;
   localparam logic [BYTE_W-1:0] RED_HIGH     = 8'd254;
   localparam logic [BYTE_W-1:0] GREEN_L12    = 8'd203;
   localparam logic [BYTE_W-1:0] GREEN_L24    = 8'd152;
   localparam logic [BYTE_W-1:0] BLUE_L48     = 8'd0;
   localparam logic [BYTE_W-1:0] BLUE_L96     = 8'd254;

   // Rain levels in quarter units
   localparam logic [BYTE_W-1:0] LEVEL_NONE = 8'd0;
   localparam logic [BYTE_W-1:0] LEVEL_1    = 8'd1;
   localparam logic [BYTE_W-1:0] LEVEL_3    = 8'd3;
   localparam logic [BYTE_W-1:0] LEVEL_6    = 8'd6;
   localparam logic [BYTE_W-1:0] LEVEL_12   = 8'd12;
   localparam logic [BYTE_W-1:0] LEVEL_24   = 8'd24;
   localparam logic [BYTE_W-1:0] LEVEL_48   = 8'd48;
   localparam logic [BYTE_W-1:0] LEVEL_96   = 8'd96;
   localparam logic [BYTE_W-1:0] LEVEL_192  = 8'd192;

   typedef struct packed {
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  alpha;
      logic [BYTE_W-1:0]  gray_value;
      logic [BYTE_W-1:0]  mask_value;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  level_code;
      logic               pixel_bad;
      logic [TOTAL_W-1:0] total_quarters;
      logic               error_seen;
   } rsp_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic             gray_mode;
      logic [WIN_W-1:0] window_x_first;
      logic [WIN_W-1:0] window_x_end;
      logic [WIN_W-1:0] window_y_first;
      logic [WIN_W-1:0] window_y_end;
   } cfg_type;

   // Decoded pixel handed to the accumulator
   typedef struct packed {
      logic [BYTE_W-1:0] level;
      logic              bad;
      logic              counted;
      logic              frame_start;
   } pix_type;

endpackage

>>> hw/rtl/mrrt_csr.sv
// Configuration registers of the masked radar rain total block.
// Depends on mrrt_pkg.
module mrrt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mrrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mrrt_pkg::WIN_W-1:0]     csr_wdata,
   output mrrt_pkg::cfg_type              cfg
);

   mrrt_pkg::cfg_type cfg_ff;
   mrrt_pkg::cfg_type cfg_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mrrt_pkg::CSR_GRAY_MODE:      cfg_in.gray_mode      = csr_wdata[0];
            mrrt_pkg::CSR_WINDOW_X_FIRST: cfg_in.window_x_first = csr_wdata;
            mrrt_pkg::CSR_WINDOW_X_END:   cfg_in.window_x_end   = csr_wdata;
            mrrt_pkg::CSR_WINDOW_Y_FIRST: cfg_in.window_y_first = csr_wdata;
            mrrt_pkg::CSR_WINDOW_Y_END:   cfg_in.window_y_end   = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gray_mode      <= 1'b0;
         cfg_ff.window_x_first <= '0;
         cfg_ff.window_x_end   <= mrrt_pkg::WIN_END_RESET;
         cfg_ff.window_y_first <= '0;
         cfg_ff.window_y_end   <= mrrt_pkg::WIN_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/mrrt_pixel.sv
// Palette decode and window qualification for one registered pixel.
// Depends on mrrt_pkg.
module mrrt_pixel (
   input  mrrt_pkg::cfg_type cfg,
   input  mrrt_pkg::req_type px,
   output mrrt_pkg::pix_type pix
);

   logic [mrrt_pkg::BYTE_W-1:0] colour_level;
   logic                        colour_bad;
   logic                        in_x;
   logic                        in_y;
   logic                        in_dim;

   // Decode the palette colour; translucent pixels give no rain
   always_comb begin
      colour_level = mrrt_pkg::LEVEL_NONE;
      colour_bad   = 1'b0;
      if (px.alpha == mrrt_pkg::ALPHA_OPAQUE) begin
         colour_bad = 1'b1;
         case (px.red)
            mrrt_pkg::RED_L1: begin
               colour_level = mrrt_pkg::LEVEL_1;
               colour_bad   = 1'b0;
            end
            mrrt_pkg::RED_L3: begin
               colour_level = mrrt_pkg::LEVEL_3;
               colour_bad   = 1'b0;
            end
            mrrt_pkg::RED_L6: begin
               colour_level = mrrt_pkg::LEVEL_6;
               colour_bad   = 1'b0;
            end
            mrrt_pkg::RED_L192: begin
               colour_level = mrrt_pkg::LEVEL_192;
               colour_bad   = 1'b0;
            end
            mrrt_pkg::RED_HIGH: begin
               colour_bad = 1'b0;
               if (px.green == mrrt_pkg::GREEN_L12) begin
                  colour_level = mrrt_pkg::LEVEL_12;
               end else if (px.green == mrrt_pkg::GREEN_L24) begin
                  colour_level = mrrt_pkg::LEVEL_24;
               end else if (px.blue == mrrt_pkg::BLUE_L48) begin
                  colour_level = mrrt_pkg::LEVEL_48;
               end else if (px.blue == mrrt_pkg::BLUE_L96) begin
                  colour_level = mrrt_pkg::LEVEL_96;
               end else begin
                  colour_bad = 1'b1;
               end
            end
            default: colour_bad = 1'b1;
         endcase
      end
   end

   // Qualify against the window and the image bound
   assign in_x   = ({1'b0, px.col} >= cfg.window_x_first) &&
                   ({1'b0, px.col} <  cfg.window_x_end);
   assign in_y   = ({1'b0, px.row} >= cfg.window_y_first) &&
                   ({1'b0, px.row} <  cfg.window_y_end);
   assign in_dim = (32'(px.col) < mrrt_pkg::MAX_DIM) &&
                   (32'(px.row) < mrrt_pkg::MAX_DIM);

   // Select the level source
   always_comb begin
      pix.level       = cfg.gray_mode ? px.gray_value : colour_level;
      pix.bad         = cfg.gray_mode ? 1'b0 : colour_bad;
      pix.counted     = (px.mask_value != '0) && in_x && in_y && in_dim;
      pix.frame_start = px.frame_start;
   end

endmodule

>>> hw/rtl/mrrt_total.sv
// Running total, sticky error and result register.
// Depends on mrrt_pkg.
module mrrt_total (
   input  logic              clock,
   input  logic              reset,
   input  logic              pix_valid,
   input  mrrt_pkg::pix_type pix,
   output logic              pix_taken,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrrt_pkg::rsp_type rsp_data
);

   logic [mrrt_pkg::TOTAL_W-1:0] total_ff;
   logic [mrrt_pkg::TOTAL_W-1:0] total_in;
   logic                         error_ff;
   logic                         error_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   mrrt_pkg::rsp_type            rsp_ff;
   mrrt_pkg::rsp_type            rsp_in;
   logic [mrrt_pkg::TOTAL_W-1:0] base;
   logic                         base_err;
   logic [mrrt_pkg::TOTAL_W:0]   sum;

   // Advance when the result register is free or being drained
   assign pix_taken = pix_valid && (!rsp_valid_ff || !rsp_stall);

   // Clear at frame start, then add and saturate
   always_comb begin
      base     = pix.frame_start ? '0 : total_ff;
      base_err = pix.frame_start ? 1'b0 : error_ff;
      sum      = {1'b0, base} + (mrrt_pkg::TOTAL_W + 1)'(pix.level);
      total_in = total_ff;
      error_in = error_ff;
      if (pix_taken) begin
         total_in = base;
         error_in = base_err;
         if (pix.counted) begin
            total_in = sum[mrrt_pkg::TOTAL_W] ? mrrt_pkg::TOTAL_MAX :
                       sum[mrrt_pkg::TOTAL_W-1:0];
            error_in = base_err | pix.bad;
         end
      end
      rsp_in.level_code     = pix.level;
      rsp_in.pixel_bad      = pix.bad;
      rsp_in.total_quarters = total_in;
      rsp_in.error_seen     = error_in;
      if (pix_taken) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result on each transfer from the input stage
   always_ff @(posedge clock) begin
      if (pix_taken) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      (pix_taken && !pix.frame_start) |=> (total_ff >= $past(total_ff)))
      else $error("running total decreased without a frame start");

   a_error_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(error_ff) |-> $past(pix_taken && pix.counted && pix.bad))
      else $error("sticky error rose without a counted bad pixel");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      pix_taken |=> (rsp_valid_ff && rsp_ff.total_quarters == total_ff))
      else $error("result register does not track the total");
`endif

endmodule

>>> hw/rtl/masked_radar_rain_total.sv
// Top level of the masked radar rain total block.
// Depends on mrrt_pkg, mrrt_csr, mrrt_pixel and mrrt_total.

// Takes one pixel per clock while the result register is not stalled, and
// returns one result per pixel through the input register, then the result
// register. The decode, window check and add-saturate of the running total
// all sit between those two registers; the total feedback loop sets the
// rate of one pixel per clock. frame_start clears the total and the sticky
// error before its own pixel is added. Configuration writes take effect on
// the next clock and should be made only while no pixel is in flight.
module masked_radar_rain_total (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mrrt_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mrrt_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [mrrt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mrrt_pkg::WIN_W-1:0]     csr_wdata
);

   mrrt_pkg::cfg_type cfg;
   mrrt_pkg::pix_type pix;
   mrrt_pkg::req_type in_data_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              pix_taken;
   logic              req_take;

   mrrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input stage: hold while the result side cannot take the pixel
   assign req_stall = in_valid_ff && !pix_taken;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (pix_taken) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   mrrt_pixel u_pixel (
      .cfg (cfg),
      .px  (in_data_ff),
      .pix (pix)
   );

   mrrt_total u_total (
      .clock     (clock),
      .reset     (reset),
      .pix_valid (in_valid_ff),
      .pix       (pix),
      .pix_taken (pix_taken),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
